FILE: sv/base64_codec_top_assert.svh
// Assertion macros for the Base64 codec. They use the clk and rst of the
// module that includes them.
`ifndef BASE64_CODEC_TOP_ASSERT_SVH
`define BASE64_CODEC_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64C_ASSERT_IMPLY(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("base64 codec check failed");

// The consequent must hold in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("base64 codec check failed");

`endif

FILE: sv/b64c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       last_of_run;
    logic       string_done;
    logic       halted;
  } out_item_t;

  // Configuration seen by the front end: the mode and a one-cycle clear pulse.
  typedef struct packed {
    logic clear;
    logic direction;
  } cfg_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0]       res;
    logic [$clog2(MAX_RESULTS)-1:0]    last_idx;
    logic                              no_data;
    logic                              eos;
    logic                              halted;
  } job_t;

  // Alphabet character for a 6-bit value.
  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + w;
    end else if (s < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (s < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // Six-bit value of a character, with a valid flag in the top bit.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return {1'b0, d[5:0]};
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/base64_codec_top.sv
// Streaming Base64 codec with the standard alphabet. The direction register
// at byte address 0 selects encoding (0) or decoding (1); writing it clears
// any string in progress, and it should only be written while the block is
// idle. Each input item carries one byte or character and an end-of-string
// mark. The front end accepts one item every cycle while its job queue has
// room, works out all the results that item causes, and queues them as one
// entry; the back end sends those results out through a single output
// register at one result per cycle while the receiver does not stall. An
// encoded byte causes one or two characters, and the final byte can cause
// up to four results (data, flush character and '=' padding). Decoding
// gives at most one byte per character, so it runs at one item per cycle
// when neither side stalls. The output register is the bottleneck when
// encoding; when decoding the input side sets the pace. A character
// outside the alphabet, including '=', halts decoding for the rest of the
// string; the halt is reported on the string's final result. Every string
// ends with a result marked string_done, which carries no_data when the last
// item produced nothing.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_codec_top_assert.svh"

module base64_codec_top
  import b64c_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Register map: one register, direction, at byte address 0.
  localparam logic REG_DIRECTION = 1'b0;

  logic direction;
  logic cfg_write;
  cfg_t cfg;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_write) begin
      direction <= pwdata[0];
    end
  end

  // The clear pulse lands together with the new direction.
  assign cfg.clear     = cfg_write;
  assign cfg.direction = direction;

  b64c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An end marker without data is always the final result of its string.
  `B64C_ASSERT_IMPLY(a_nodata_ends, out_valid && out_item.no_data,
                     out_item.last_of_run && out_item.string_done)
  // The end of a string is also the end of its item's run.
  `B64C_ASSERT_IMPLY(a_done_is_last, out_valid && out_item.string_done,
                     out_item.last_of_run)
  // A halt is only reported on the final result of a string.
  `B64C_ASSERT_IMPLY(a_halt_at_end, out_valid && out_item.halted,
                     out_item.string_done)
  // The rest of a run is already queued, so it follows without a gap.
  `B64C_ASSERT_NEXT(a_run_unbroken,
                    out_valid && !out_stall && !out_item.last_of_run, out_valid)

endmodule

`default_nettype wire

FILE: sv/b64c_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_front
  import b64c_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  logic [15:0] acc, acc_next;
  logic [3:0]  pend, pend_next;
  logic [1:0]  cnt, cnt_next;
  logic        stopped, stopped_next;
  logic        accept, job_push;

  logic [15:0] a;
  logic [3:0]  p;
  logic [5:0]  s0, s1;
  logic [1:0]  nchar, pads, cnt_after;
  logic [2:0]  total;
  logic [6:0]  dv;
  logic        eos;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && job_push;
  assign eos      = in_item.end_of_string;

  always_comb begin
    acc_next     = acc;
    pend_next    = pend;
    cnt_next     = cnt;
    stopped_next = stopped;
    job_push     = 1'b0;
    q_job        = '0;
    a            = '0;
    p            = '0;
    s0           = '0;
    s1           = '0;
    nchar        = '0;
    pads         = '0;
    cnt_after    = '0;
    total        = '0;
    dv           = '0;
    if (!cfg.direction) begin
      a = {acc[7:0], in_item.in_byte};
      p = pend + 4'd8;
      case (p)
        4'd12: begin
          s0 = a[11:6];
          s1 = a[5:0];
          nchar = 2'd2;
          pend_next = 4'd0;
        end
        4'd10: begin
          s0 = a[9:4];
          nchar = 2'd1;
          pend_next = 4'd4;
        end
        default: begin
          s0 = a[7:2];
          nchar = 2'd1;
          pend_next = 4'd2;
        end
      endcase
      // At the end of the string the leftover bits go out zero-padded.
      if (eos && pend_next != 4'd0) begin
        s1 = (pend_next == 4'd4) ? {a[3:0], 2'b00} : {a[1:0], 4'b0000};
        nchar = 2'd2;
      end
      cnt_after = cnt + nchar;
      pads = eos ? 2'(2'd0 - cnt_after) : 2'd0;
      total = {1'b0, nchar} + {1'b0, pads};
      acc_next = a;
      cnt_next = cnt_after;
      job_push = 1'b1;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (k == 0) begin
          q_job.res[k] = char_of(s0);
        end else if (k == 1 && nchar == 2'd2) begin
          q_job.res[k] = char_of(s1);
        end else begin
          q_job.res[k] = PAD_CHAR;
        end
      end
      q_job.last_idx = 2'(total - 3'd1);
    end else begin
      if (!stopped) begin
        dv = sextet_of(in_item.in_byte);
        if (!dv[6]) begin
          stopped_next = 1'b1;
        end else begin
          a = {acc[9:0], dv[5:0]};
          p = pend + 4'd6;
          acc_next = a;
          pend_next = p;
          if (p >= 4'd8) begin
            case (p)
              4'd12:   q_job.res[0] = a[11:4];
              4'd10:   q_job.res[0] = a[9:2];
              default: q_job.res[0] = a[7:0];
            endcase
            pend_next = p - 4'd8;
            job_push = 1'b1;
          end
        end
      end
      q_job.halted = stopped_next;
      // A final item that yields no byte still marks the end of the string.
      if (eos && !job_push) begin
        job_push = 1'b1;
        q_job.no_data = 1'b1;
      end
    end
    q_job.eos = eos;
    if (accept && eos) begin
      acc_next     = '0;
      pend_next    = '0;
      cnt_next     = '0;
      stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      acc     <= '0;
      pend    <= '0;
      cnt     <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      acc     <= acc_next;
      pend    <= pend_next;
      cnt     <= cnt_next;
      stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64c_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_queue
  import b64c_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64c_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_back
  import b64c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire job_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  logic [$clog2(MAX_RESULTS)-1:0] idx;
  logic                           load, last;
  out_item_t                      nxt;

  assign load  = (!out_valid || !out_stall) && !q_empty;
  assign last  = (idx == q_head.last_idx);
  assign q_pop = load && last;

  always_comb begin
    nxt.out_byte    = q_head.res[idx];
    nxt.no_data     = q_head.no_data;
    nxt.last_of_run = last;
    nxt.string_done = last && q_head.eos;
    nxt.halted      = last && q_head.eos && q_head.halted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= nxt;
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the streaming Base64 codec. The bench predicts
// every result of an accepted item from its own model of the accumulator.
// It compares the results in order, field by field, with what the block
// sends out.
module testbench;
  import b64c_pkg::*;

  // Direction register values and register addresses on the APB port.
  localparam logic       DIR_ENCODE         = 1'b0;
  localparam logic       DIR_DECODE         = 1'b1;
  localparam logic [2:0] REG_DIRECTION_ADDR = 3'd0;
  // The first address past the register list. A write here must change nothing.
  localparam logic [2:0] REG_BEYOND_ADDR    = 3'd4;

  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 19;
  // Cycles allowed after the last expected result for work still in flight.
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  base64_codec_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and the results that accepted items must
  // still produce, oldest first.
  in_item_t  items_to_send[$];
  out_item_t predicted_results[$];

  // The bench's own copy of the codec state and the direction register.
  logic        decode_mode = DIR_ENCODE;
  logic [15:0] acc_bits = '0;
  logic [3:0]  acc_count = '0;
  logic [1:0]  chars_mod4 = '0;
  logic        decode_halted = 1'b0;

  bit mismatch_seen = 1'b0;
  bit item_taken = 1'b0;
  int idle_pct = IDLE_PCT;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Alphabet character of a six-bit value. The first character sits in the
  // top byte of the packed constant.
  function automatic logic [7:0] b64_char(input int sextet);
    return B64_ALPHABET[8*(63-sextet) +: 8];
  endfunction

  // Six-bit value of a character, or -1 when the character is outside the
  // alphabet. The pad character '=' is outside as well.
  function automatic int alphabet_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_char(i) == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic out_item_t data_result(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    return r;
  endfunction

  function automatic void clear_string_state();
    acc_bits = '0;
    acc_count = '0;
    chars_mod4 = '0;
    decode_halted = 1'b0;
  endfunction

  // Works out every result that one accepted item causes and appends the
  // results to the expectations.
  task automatic predict_codec_results(input in_item_t it);
    out_item_t   step_out[$];
    out_item_t   r;
    logic [15:0] shifted;
    int          v;
    if (decode_mode == DIR_ENCODE) begin
      acc_bits = {acc_bits[7:0], it.in_byte};
      acc_count = acc_count + 4'd8;
      while (acc_count >= 4'd6) begin
        shifted = acc_bits >> (acc_count - 4'd6);
        step_out.insert(step_out.size(), data_result(b64_char(shifted[5:0])));
        chars_mod4 = chars_mod4 + 2'd1;
        acc_count = acc_count - 4'd6;
      end
      if (it.end_of_string) begin
        // Leftover bits go out as one character, zero-filled on the right.
        if (acc_count != 4'd0) begin
          shifted = acc_bits << (4'd6 - acc_count);
          step_out.insert(step_out.size(), data_result(b64_char(shifted[5:0])));
          chars_mod4 = chars_mod4 + 2'd1;
        end
        while (chars_mod4 != 2'd0) begin
          step_out.insert(step_out.size(), data_result(PAD_CHAR));
          chars_mod4 = chars_mod4 + 2'd1;
        end
      end
    end else if (!decode_halted) begin
      v = alphabet_index(it.in_byte);
      if (v < 0) begin
        decode_halted = 1'b1;
      end else begin
        acc_bits = {acc_bits[9:0], v[5:0]};
        acc_count = acc_count + 4'd6;
        if (acc_count >= 4'd8) begin
          shifted = acc_bits >> (acc_count - 4'd8);
          step_out.insert(step_out.size(), data_result(shifted[7:0]));
          acc_count = acc_count - 4'd8;
        end
      end
    end
    // An end mark always produces a result, even when no byte is ready.
    if (it.end_of_string && step_out.size() == 0) begin
      r = '0;
      r.no_data = 1'b1;
      step_out.insert(step_out.size(), r);
    end
    if (step_out.size() != 0) begin
      r = step_out.pop_back();
      r.last_of_run = 1'b1;
      if (it.end_of_string) begin
        r.string_done = 1'b1;
        r.halted = decode_halted;
      end
      step_out.insert(step_out.size(), r);
    end
    if (it.end_of_string) begin
      clear_string_state();
    end
    foreach (step_out[i]) begin
      predicted_results.insert(predicted_results.size(), step_out[i]);
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // Driver. It changes the input at the falling edge. A new item is offered
  // only once the current one has been taken, so a stalled item holds still.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_item <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input side. The prediction runs at the edge at which the item is taken.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_codec_results(in_item);
      item_taken = 1'b1;
    end
  end

  // Receiver. It stalls at random. On request it holds off for a long run
  // of cycles, so that the job queue fills up and the input stalls.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Output side. Each result taken is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result: out_byte %0h no_data %0b", out_item.out_byte,
               out_item.no_data);
        mismatch_seen = 1'b1;
      end else begin
        want = predicted_results.pop_front();
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("no_data", want.no_data, out_item.no_data);
        check_field("last_of_run", want.last_of_run, out_item.last_of_run);
        check_field("string_done", want.string_done, out_item.string_done);
        check_field("halted", want.halted, out_item.halted);
      end
    end
  end

  // Watchdog. It counts cycles in which neither side takes an item. The
  // longest quiet stretch in a correct run is the receiver's hold-off, and
  // the settling pause around a register write.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic [7:0] b, input logic eos);
    in_item_t it;
    it.in_byte = b;
    it.end_of_string = eos;
    items_to_send.insert(items_to_send.size(), it);
  endtask

  // Queues a text one character per item. The end mark goes on the last
  // character only when the string is to be closed.
  task automatic queue_text(input string text, input logic close);
    for (int i = 0; i < text.len(); i++) begin
      queue_item(text[i], close && (i == text.len() - 1));
    end
  endtask

  // Random byte strings for encoding. Most are short, and a few are long
  // enough to wrap the accumulator many times.
  task automatic queue_encode_strings(input int target);
    int count;
    int len;
    count = 0;
    while (count < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        queue_item(8'($urandom_range(0, 255)), i == len - 1);
      end
      count += len;
    end
  endtask

  // Strings for decoding. Most are well formed, in groups of four
  // characters, with zero, one or two '=' at the end. Others are runs of
  // alphabet characters broken by one character outside the alphabet, or
  // plain noise over the full byte range.
  task automatic queue_decode_strings(input int target);
    logic [7:0] chars[$];
    logic [7:0] c;
    int         count;
    int         kind;
    int         len;
    int         spot;
    count = 0;
    while (count < target) begin
      chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = 4 * $urandom_range(1, 3);
        repeat (len) chars.insert(chars.size(), b64_char($urandom_range(0, 63)));
        spot = $urandom_range(0, 2);
        for (int i = 0; i < spot; i++) begin
          chars[len-1-i] = PAD_CHAR;
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 9);
        repeat (len) chars.insert(chars.size(), b64_char($urandom_range(0, 63)));
        do begin
          c = 8'($urandom_range(0, 255));
        end while (alphabet_index(c) >= 0);
        chars[$urandom_range(0, len - 1)] = c;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
      end
      foreach (chars[i]) begin
        queue_item(chars[i], i == chars.size() - 1);
      end
      count += chars.size();
    end
  endtask

  // Waits until every queued item has been taken and every expected result
  // has arrived. A final item that caused nothing may still be in flight,
  // so a few more cycles pass.
  task automatic drain_codec();
    while (items_to_send.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle. The register takes the
  // value at the rising edge of the access cycle, and so does the bench's
  // own copy.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == REG_DIRECTION_ADDR) begin
      decode_mode = data[0];
      clear_string_state();
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      mismatch_seen = 1'b1;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sets the direction. The bits above bit 0 are random and must be
  // ignored. A read-back then confirms the value.
  task automatic set_direction(input logic dir);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[0] = dir;
    apb_write(REG_DIRECTION_ADDR, wdata);
    apb_read_check(REG_DIRECTION_ADDR, {31'b0, dir});
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A write past the register list must leave the direction at its
    // reset value of encode.
    apb_write(REG_BEYOND_ADDR, 32'hFFFF_FFFF);
    apb_read_check(REG_DIRECTION_ADDR, {31'b0, DIR_ENCODE});
    set_direction(DIR_ENCODE);

    // Encoding: a single zero byte gives two characters and two pads. Two
    // all-ones bytes give three characters and one pad. Three bytes fill
    // whole groups, so no pad follows.
    queue_item(8'h00, 1'b1);
    queue_item(8'hFF, 1'b0);
    queue_item(8'hFF, 1'b1);
    queue_item(8'h80, 1'b0);
    queue_item(8'h7F, 1'b0);
    queue_item(8'h55, 1'b1);
    drain_codec();

    // A string left open is cut short when the direction is written.
    queue_item(8'hAA, 1'b0);
    queue_item(8'h01, 1'b1 == 1'b0);
    drain_codec();
    set_direction(DIR_DECODE);

    // Decoding: the alphabet's end characters. Then '=' halts the string,
    // and the '=' after it is dropped. A lone character gives only an end
    // mark. Two characters give one byte, and four bits are dropped.
    queue_text("AZaz09+/", 1'b1);
    queue_text("TQ==", 1'b1);
    queue_text("Q", 1'b1);
    queue_text("QQ", 1'b1);
    drain_codec();

    // An open decode string is also cut short by a direction write.
    queue_text("TW", 1'b0);
    drain_codec();
    set_direction(DIR_ENCODE);

    // Random phases, alternating the direction. The first runs with no
    // idling on either side. A later one holds the receiver off for a long
    // stretch while the sender keeps offering items.
    idle_pct = 0;
    queue_encode_strings(35);
    drain_codec();
    idle_pct = IDLE_PCT;

    set_direction(DIR_DECODE);
    queue_decode_strings(35);
    drain_codec();

    set_direction(DIR_ENCODE);
    queue_encode_strings(35);
    hold_request = 1'b1;
    drain_codec();

    set_direction(DIR_DECODE);
    queue_decode_strings(35);
    drain_codec();

    set_direction(DIR_ENCODE);
    queue_encode_strings(30);
    drain_codec();

    set_direction(DIR_DECODE);
    queue_decode_strings(35);
    drain_codec();

    if (!mismatch_seen && predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (predicted_results.size() != 0) begin
        $error("%0d expected results never arrived", predicted_results.size());
      end
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
